// ===== sv/dfr_pkg.sv =====
// Shared types and constants for the delimited frame receiver.
// No dependencies; every other file in the block imports this package.
package dfr_pkg;

    localparam int FrameCapacity = 64;
    localparam int ByteW         = 8;
    localparam int LenW          = 6;
    localparam int CmdDepth      = 2;

    localparam logic [ByteW-1:0] START_DELIM_RESET = 8'd60;
    localparam logic [ByteW-1:0] END_DELIM_RESET   = 8'd62;

    localparam logic OP_BYTE = 1'b0;
    localparam logic OP_READ = 1'b1;

    localparam logic REG_START_DELIM = 1'b0;
    localparam logic REG_END_DELIM   = 1'b1;

    typedef enum logic [1:0] {
        STATUS_NONE  = 2'd0,
        STATUS_DATA  = 2'd1,
        STATUS_EMPTY = 2'd2
    } status_t;

    typedef struct packed {
        status_t             status;
        logic [LenW-1:0]     length;
        logic                overflow;
    } read_cmd_t;

    typedef struct packed {
        logic [ByteW-1:0] start_delim;
        logic [ByteW-1:0] end_delim;
    } delim_cfg_t;

endpackage

// ===== sv/dfr_front.sv =====
// Front end: accepts transactions, tracks the frame being received and
// writes payload bytes to the store. Depends on dfr_pkg.
module dfr_front #(
    parameter int FRAME_CAPACITY = dfr_pkg::FrameCapacity
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  dfr_pkg::delim_cfg_t                    cfg,
    input  logic                                   item_valid,
    output logic                                   item_ready,
    input  logic                                   opcode,
    input  logic [dfr_pkg::ByteW-1:0]              rx_byte,
    input  logic                                   store_busy,
    input  logic                                   cmd_full,
    output logic                                   cmd_push,
    output dfr_pkg::read_cmd_t                     cmd_data,
    output logic                                   wr_en,
    output logic [$clog2(FRAME_CAPACITY)-1:0]      wr_addr,
    output logic [dfr_pkg::ByteW-1:0]              wr_data
);
    import dfr_pkg::*;

    localparam int IdxW = $clog2(FRAME_CAPACITY);
    localparam logic [LenW-1:0] FILL_MAX = LenW'(FRAME_CAPACITY - 1);

    logic            in_frame_reg, in_frame_next;
    logic [LenW-1:0] fill_count_reg, fill_count_next;
    logic            fill_ovf_reg, fill_ovf_next;
    logic            frame_ready_reg, frame_ready_next;
    logic [LenW-1:0] ready_len_reg, ready_len_next;
    logic            ready_ovf_reg, ready_ovf_next;
    logic            byte_stores;
    logic            accept;

    assign byte_stores = in_frame_reg && (rx_byte != cfg.end_delim)
                         && (fill_count_reg < FILL_MAX);
    assign item_ready  = (opcode == OP_READ) ? !cmd_full : !(byte_stores && store_busy);
    assign accept      = item_valid && item_ready;
    assign cmd_push    = accept && (opcode == OP_READ);
    assign wr_addr     = fill_count_reg[IdxW-1:0];
    assign wr_data     = rx_byte;

    always_comb
    begin
        if (!frame_ready_reg)
        begin
            cmd_data.status   = STATUS_NONE;
            cmd_data.length   = '0;
            cmd_data.overflow = 1'b0;
        end
        else
        begin
            cmd_data.status   = (ready_len_reg == '0) ? STATUS_EMPTY : STATUS_DATA;
            cmd_data.length   = ready_len_reg;
            cmd_data.overflow = ready_ovf_reg;
        end
    end

    always_comb
    begin
        in_frame_next    = in_frame_reg;
        fill_count_next  = fill_count_reg;
        fill_ovf_next    = fill_ovf_reg;
        frame_ready_next = frame_ready_reg;
        ready_len_next   = ready_len_reg;
        ready_ovf_next   = ready_ovf_reg;
        wr_en            = 1'b0;
        if (accept)
        begin
            if (opcode == OP_BYTE)
            begin
                if (!in_frame_reg)
                begin
                    if (rx_byte == cfg.start_delim)
                    begin
                        in_frame_next = 1'b1;
                    end
                end
                else if (rx_byte == cfg.end_delim)
                begin
                    frame_ready_next = 1'b1;
                    ready_len_next   = fill_count_reg;
                    ready_ovf_next   = fill_ovf_reg;
                    in_frame_next    = 1'b0;
                    fill_count_next  = '0;
                    fill_ovf_next    = 1'b0;
                end
                else if (fill_count_reg < FILL_MAX)
                begin
                    wr_en           = 1'b1;
                    fill_count_next = fill_count_reg + 1'b1;
                end
                else
                begin
                    fill_ovf_next = 1'b1;
                end
            end
            else
            begin
                frame_ready_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_frame_reg    <= 1'b0;
            fill_count_reg  <= '0;
            fill_ovf_reg    <= 1'b0;
            frame_ready_reg <= 1'b0;
            ready_len_reg   <= '0;
            ready_ovf_reg   <= 1'b0;
        end
        else
        begin
            in_frame_reg    <= in_frame_next;
            fill_count_reg  <= fill_count_next;
            fill_ovf_reg    <= fill_ovf_next;
            frame_ready_reg <= frame_ready_next;
            ready_len_reg   <= ready_len_next;
            ready_ovf_reg   <= ready_ovf_next;
        end
    end

    // The store must never change while a queued read still has bytes to fetch.
    a_no_write_when_busy: assert property (@(posedge clk) disable iff (!rst_n)
        wr_en |-> !store_busy)
        else $error("frame store written while a read is outstanding");

    a_fill_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        fill_count_reg <= FILL_MAX)
        else $error("fill count beyond capacity");

    a_read_clears_ready: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_push |=> !frame_ready_reg)
        else $error("frame still ready after a read");

endmodule

// ===== sv/dfr_cmd_fifo.sv =====
// Short queue of read commands between the front and back ends.
// Depends on dfr_pkg; the depth is a power of two so the pointers wrap.
module dfr_cmd_fifo (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    input  dfr_pkg::read_cmd_t din,
    input  logic               pop,
    output dfr_pkg::read_cmd_t dout,
    output logic               not_empty,
    output logic               full
);
    import dfr_pkg::*;

    localparam int PtrW = $clog2(CmdDepth);
    localparam int CntW = $clog2(CmdDepth + 1);

    read_cmd_t         entry_reg [CmdDepth];
    logic [PtrW-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PtrW-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CntW-1:0]   count_reg, count_next;

    assign dout      = entry_reg[rd_ptr_reg];
    assign not_empty = (count_reg != '0);
    assign full      = (count_reg == CntW'(CmdDepth));

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= din;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
        full |-> !push || pop)
        else $error("command queue overrun");

    a_no_underrun: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> not_empty)
        else $error("command queue underrun");

    a_count_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CntW'(CmdDepth))
        else $error("command queue count out of range");

endmodule

// ===== sv/dfr_back.sv =====
// Back end: holds the frame store and streams queued read commands out
// through a fetch stage and an output register. Depends on dfr_pkg.
module dfr_back #(
    parameter int FRAME_CAPACITY = dfr_pkg::FrameCapacity
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                wr_en,
    input  logic [$clog2(FRAME_CAPACITY)-1:0]   wr_addr,
    input  logic [dfr_pkg::ByteW-1:0]           wr_data,
    input  logic                                cmd_valid,
    input  dfr_pkg::read_cmd_t                  cmd,
    output logic                                cmd_pop,
    output logic                                result_valid,
    input  logic                                result_ready,
    output logic [1:0]                          status,
    output logic [dfr_pkg::ByteW-1:0]           data,
    output logic                                last,
    output logic [dfr_pkg::LenW-1:0]            frame_length,
    output logic                                overflow
);
    import dfr_pkg::*;

    localparam int IdxW = $clog2(FRAME_CAPACITY);

    logic [ByteW-1:0] store_mem [FRAME_CAPACITY];
    logic [ByteW-1:0] rd_data_reg;

    logic [IdxW-1:0]  idx_reg, idx_next;
    logic             head_last;
    logic             s1_load;
    logic             s1_move;

    logic             s1_valid_reg, s1_valid_next;
    status_t          s1_status_reg;
    logic             s1_last_reg;
    logic [LenW-1:0]  s1_len_reg;
    logic             s1_ovf_reg;

    logic             out_valid_reg, out_valid_next;
    status_t          out_status_reg;
    logic [ByteW-1:0] out_data_reg;
    logic             out_last_reg;
    logic [LenW-1:0]  out_len_reg;
    logic             out_ovf_reg;

    assign head_last = (cmd.status != STATUS_DATA)
                       || (LenW'(idx_reg) == LenW'(cmd.length - 1'b1));
    assign s1_move   = s1_valid_reg && (!out_valid_reg || result_ready);
    assign s1_load   = cmd_valid && (!s1_valid_reg || s1_move);
    assign cmd_pop   = s1_load && head_last;

    always_comb
    begin
        idx_next = idx_reg;
        if (s1_load)
        begin
            idx_next = head_last ? '0 : idx_reg + 1'b1;
        end
        s1_valid_next  = s1_load ? 1'b1 : (s1_move ? 1'b0 : s1_valid_reg);
        out_valid_next = s1_move ? 1'b1 : (result_ready ? 1'b0 : out_valid_reg);
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            store_mem[wr_addr] <= wr_data;
        end
        if (s1_load)
        begin
            rd_data_reg <= store_mem[idx_reg];
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_load)
        begin
            s1_status_reg <= cmd.status;
            s1_last_reg   <= head_last;
            s1_len_reg    <= cmd.length;
            s1_ovf_reg    <= cmd.overflow;
        end
        if (s1_move)
        begin
            out_status_reg <= s1_status_reg;
            out_data_reg   <= (s1_status_reg == STATUS_DATA) ? rd_data_reg : '0;
            out_last_reg   <= s1_last_reg;
            out_len_reg    <= s1_len_reg;
            out_ovf_reg    <= s1_ovf_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg       <= '0;
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            idx_reg       <= idx_next;
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign result_valid = out_valid_reg;
    assign status       = out_status_reg;
    assign data         = out_data_reg;
    assign last         = out_last_reg;
    assign frame_length = out_len_reg;
    assign overflow     = out_ovf_reg;

    a_none_result_clean: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && (out_status_reg == STATUS_NONE)
        |-> out_last_reg && (out_len_reg == '0) && !out_ovf_reg && (out_data_reg == '0))
        else $error("malformed no-frame result");

    a_data_has_length: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && (out_status_reg == STATUS_DATA) |-> out_len_reg != '0)
        else $error("data result with zero frame length");

    a_idx_in_frame: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_valid && (cmd.status == STATUS_DATA) |-> LenW'(idx_reg) < cmd.length)
        else $error("read index beyond frame length");

endmodule

// ===== sv/delimited_frame_receiver_top.sv =====
// Top level of the delimited frame receiver: configuration registers and
// the front end, command queue and back end. Depends on dfr_pkg.
//
// The item channel (item_valid/item_ready, opcode, rx_byte) carries either a
// received byte or a read request. A start delimiter opens a frame while
// idle; later bytes are stored until the end delimiter closes the frame and
// marks it ready. A read request yields one result transaction per stored
// byte, or a single empty-frame or no-frame transaction, on the result
// channel (result_valid/result_ready) with last set on the final one.
// Received bytes are taken one per cycle unless held as below. A read request
// passes the command queue, the fetch stage (registered store read) and the
// output register; with result_ready high a frame streams one byte per cycle.
// A payload byte that would be stored waits while a read is queued or still
// streaming; other transactions are unaffected. When the result side stalls,
// the output register and fetch stage hold, and up to two read requests
// queue before item_ready falls for further reads.
// After reset no frame is ready and the delimiters are '<' and '>'. They
// are written over the APB port at byte addresses 0 and 4.
module delimited_frame_receiver_top #(
    parameter int FRAME_CAPACITY = dfr_pkg::FrameCapacity
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [2:0]                  paddr,
    input  logic [31:0]                 pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready,
    input  logic                        item_valid,
    output logic                        item_ready,
    input  logic                        opcode,
    input  logic [dfr_pkg::ByteW-1:0]   rx_byte,
    output logic                        result_valid,
    input  logic                        result_ready,
    output logic [1:0]                  status,
    output logic [dfr_pkg::ByteW-1:0]   data,
    output logic                        last,
    output logic [dfr_pkg::LenW-1:0]    frame_length,
    output logic                        overflow
);
    import dfr_pkg::*;

    localparam int IdxW = $clog2(FRAME_CAPACITY);

    delim_cfg_t      cfg_reg, cfg_next;
    logic            cfg_write;
    logic            store_busy;
    logic            cmd_full;
    logic            cmd_push;
    logic            cmd_pop;
    read_cmd_t       cmd_in;
    read_cmd_t       cmd_head;
    logic            wr_en;
    logic [IdxW-1:0] wr_addr;
    logic [ByteW-1:0] wr_data;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_write)
        begin
            case (paddr[2])
                REG_START_DELIM: cfg_next.start_delim = pwdata[ByteW-1:0];
                REG_END_DELIM:   cfg_next.end_delim   = pwdata[ByteW-1:0];
                default:         cfg_next = cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[2])
            REG_START_DELIM: prdata = {{(32 - ByteW){1'b0}}, cfg_reg.start_delim};
            REG_END_DELIM:   prdata = {{(32 - ByteW){1'b0}}, cfg_reg.end_delim};
            default:         prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.start_delim <= START_DELIM_RESET;
            cfg_reg.end_delim   <= END_DELIM_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    dfr_front #(
        .FRAME_CAPACITY (FRAME_CAPACITY)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_reg),
        .item_valid (item_valid),
        .item_ready (item_ready),
        .opcode     (opcode),
        .rx_byte    (rx_byte),
        .store_busy (store_busy),
        .cmd_full   (cmd_full),
        .cmd_push   (cmd_push),
        .cmd_data   (cmd_in),
        .wr_en      (wr_en),
        .wr_addr    (wr_addr),
        .wr_data    (wr_data)
    );

    dfr_cmd_fifo u_cmd_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (cmd_push),
        .din       (cmd_in),
        .pop       (cmd_pop),
        .dout      (cmd_head),
        .not_empty (store_busy),
        .full      (cmd_full)
    );

    dfr_back #(
        .FRAME_CAPACITY (FRAME_CAPACITY)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .wr_en        (wr_en),
        .wr_addr      (wr_addr),
        .wr_data      (wr_data),
        .cmd_valid    (store_busy),
        .cmd          (cmd_head),
        .cmd_pop      (cmd_pop),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .status       (status),
        .data         (data),
        .last         (last),
        .frame_length (frame_length),
        .overflow     (overflow)
    );

endmodule
